FILE: hdl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants for the preemptive tick scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

	localparam int SLOTS_DEF = 16;

	localparam int KIND_W  = 1;
	localparam int SLOT_W  = 4;
	localparam int TIME_W  = 16;
	localparam int WORK_W  = 16;
	localparam int RANK_W  = 8;
	localparam int TICK_W  = 24;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	localparam logic MODE_SRT  = 1'b0;
	localparam logic MODE_PRIO = 1'b1;

	// One slot of the task table as stored in RAM
	typedef struct packed {
		logic [WORK_W-1:0] rem;
		logic [WORK_W-1:0] orig;
		logic [TIME_W-1:0] arr;
		logic [RANK_W-1:0] rank;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_UPDATE
	} state_t;

endpackage

FILE: hdl/pts_ram.sv
// ----------------------------------------------------------------------------
// pts_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hdl/preemptive_tick_scheduler.sv
// A load word is taken in ST_IDLE and writes its slot at once.
// A tick word is scanned in ST_SCAN with one RAM read per slot; ST_DRAIN compares the last
// entry, and ST_UPDATE writes back the pick and loads the output register, holding while the
// previous result word is not yet taken; only then does ST_IDLE take the next word, so a new
// tick is not accepted before the last one's result is loaded.
// Reset: busy flags, tick counter, previous pick and policy clear at once; no clearing pass.
// ----------------------------------------------------------------------------
// preemptive_tick_scheduler
// Shortest-remaining-time or priority scheduler over a RAM-held task table.
// ----------------------------------------------------------------------------
module preemptive_tick_scheduler
	import pts_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data,
	// input words
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [KIND_W-1:0] kind,
	input  logic [SLOT_W-1:0] slot,
	input  logic [TIME_W-1:0] arrival_time,
	input  logic [WORK_W-1:0] burst_length,
	input  logic [RANK_W-1:0] priority_level,
	// result words
	output logic              out_valid,
	input  logic              out_ready,
	output logic              ran,
	output logic [SLOT_W-1:0] running_slot,
	output logic              switched,
	output logic [TICK_W-1:0] start_tick,
	output logic              finished,
	output logic [TICK_W-1:0] complete_time,
	output logic [TICK_W-1:0] wait_time,
	output logic [TICK_W-1:0] turnaround_time,
	output logic              all_done
);

	localparam int IDX_W = $clog2(SLOTS);

	state_t state_q, state_d;

	logic [SLOTS-1:0]  busy_q;
	logic              policy_q;
	logic [TICK_W-1:0] now_q;
	logic              prev_valid_q;
	logic [IDX_W-1:0]  prev_idx_q;

	logic [IDX_W-1:0]  rd_idx_q;
	logic              cmp_valid_s1;
	logic [IDX_W-1:0]  cmp_idx_s1;
	logic              cmp_busy_s1;

	logic              best_found_q;
	logic [IDX_W-1:0]  best_idx_q;
	entry_t            best_q;

	logic              ram_we, ram_re;
	logic [IDX_W-1:0]  ram_waddr;
	entry_t            ram_wdata, ram_rdata;
	logic [ENTRY_W-1:0] ram_rdata_raw;

	logic              in_fire, load_fire, tick_fire, commit;
	logic [IDX_W-1:0]  load_idx;
	logic              load_ok;

	logic [WORK_W-1:0] key_rd, key_best;
	logic              eligible, take;

	logic [WORK_W-1:0] rem_next;
	logic [SLOTS-1:0]  busy_after;
	logic [TICK_W-1:0] turn, wait_v;

	assign ram_rdata = entry_t'(ram_rdata_raw);

	pts_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SLOTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rd_idx_q),
		.rdata (ram_rdata_raw)
	);

	assign in_fire   = in_valid && in_ready;
	assign load_fire = in_fire && (kind == KIND_LOAD);
	assign tick_fire = in_fire && (kind == KIND_TICK);
	assign load_idx  = IDX_W'(slot);
	assign load_ok   = int'(slot) < SLOTS;
	assign cfg_ready = 1'b1;

	// next state and control
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		ram_re   = 1'b0;
		commit   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (tick_fire) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				ram_re = 1'b1;
				if (rd_idx_q == IDX_W'(SLOTS - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				// hold until the output register is free
				if (!out_valid || out_ready) begin
					commit  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// write port: loads in idle, write-back of the pick on commit
	assign rem_next = best_q.rem - WORK_W'(1);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = load_idx;
		ram_wdata = '{rem: burst_length, orig: burst_length,
			arr: arrival_time, rank: priority_level};
		if (load_fire && load_ok) begin
			ram_we = 1'b1;
		end else if (commit && best_found_q) begin
			ram_we    = 1'b1;
			ram_waddr = best_idx_q;
			ram_wdata = '{rem: rem_next, orig: best_q.orig,
				arr: best_q.arr, rank: best_q.rank};
		end
	end

	// compare the entry read last cycle against the running best
	assign key_rd   = (policy_q == MODE_PRIO) ? WORK_W'(ram_rdata.rank) : ram_rdata.rem;
	assign key_best = (policy_q == MODE_PRIO) ? WORK_W'(best_q.rank) : best_q.rem;
	assign eligible = cmp_valid_s1 && cmp_busy_s1 && (TICK_W'(ram_rdata.arr) < now_q);
	assign take     = eligible && (!best_found_q || (key_rd < key_best));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q     <= '0;
			cmp_valid_s1 <= 1'b0;
			best_found_q <= 1'b0;
		end else begin
			cmp_valid_s1 <= ram_re;
			if (tick_fire) begin
				rd_idx_q     <= '0;
				best_found_q <= 1'b0;
			end else begin
				if (ram_re) begin
					rd_idx_q <= rd_idx_q + IDX_W'(1);
				end
				if (take) begin
					best_found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1  <= rd_idx_q;
		cmp_busy_s1 <= busy_q[rd_idx_q];
		if (take) begin
			best_idx_q <= cmp_idx_s1;
			best_q     <= ram_rdata;
		end
	end

	// completion figures
	assign turn   = now_q - TICK_W'(best_q.arr);
	assign wait_v = (turn >= TICK_W'(best_q.orig)) ? turn - TICK_W'(best_q.orig) : '0;

	always_comb begin
		busy_after = busy_q;
		if (best_found_q && rem_next == '0) begin
			busy_after[best_idx_q] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= '0;
			policy_q     <= MODE_SRT;
			now_q        <= '0;
			prev_valid_q <= 1'b0;
			prev_idx_q   <= '0;
			out_valid    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				policy_q <= cfg_data;
			end
			if (load_fire && load_ok) begin
				busy_q[load_idx] <= (burst_length != '0);
			end
			if (tick_fire) begin
				now_q <= now_q + TICK_W'(1);
			end
			if (commit) begin
				out_valid    <= 1'b1;
				busy_q       <= busy_after;
				prev_valid_q <= best_found_q;
				prev_idx_q   <= best_idx_q;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (commit) begin
			ran             <= best_found_q;
			running_slot    <= best_found_q ? SLOT_W'(best_idx_q) : '0;
			switched        <= best_found_q && (!prev_valid_q || prev_idx_q != best_idx_q);
			start_tick      <= now_q - TICK_W'(1);
			all_done        <= (busy_after == '0);
			if (best_found_q && rem_next == '0) begin
				finished        <= 1'b1;
				complete_time   <= now_q;
				wait_time       <= wait_v;
				turnaround_time <= turn;
			end else begin
				finished        <= 1'b0;
				complete_time   <= '0;
				wait_time       <= '0;
				turnaround_time <= '0;
			end
		end
	end

endmodule
